>>> rtl/cfa_pkg.sv
// ----------------------------------------------------------------------------
// Colored first-fit allocator package
// Shared types and constants for the region allocator and its channels.
// ----------------------------------------------------------------------------
package cfa_pkg;

	localparam int unsigned OP_W       = 2;
	localparam int unsigned ENTRY_W    = 5;
	localparam int unsigned ADDR_W     = 64;
	localparam int unsigned SIZE_W     = 64;
	localparam int unsigned COLOR_W    = 16;
	localparam int unsigned PART_W     = 32;
	localparam int unsigned SLOT_W     = 32;
	localparam int unsigned REGCOUNT_W = 6;
	localparam int unsigned PART_SEL_W = 3;

	localparam logic [SLOT_W-1:0] SLOT_RESET = SLOT_W'(10);

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	typedef struct packed {
		logic               en;
		logic [ENTRY_W-1:0] idx;
		logic [ADDR_W-1:0]  base;
		logic [SIZE_W-1:0]  size;
		logic [COLOR_W-1:0] color;
	} tbl_wr_t;

endpackage

>>> rtl/cfa_if.sv
// ----------------------------------------------------------------------------
// Colored first-fit allocator channels
// Request, response and configuration channels with valid/ready transfers.
// ----------------------------------------------------------------------------
interface cfa_req_if;
	import cfa_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [ENTRY_W-1:0]  entry_index;
	logic [ADDR_W-1:0]   address;
	logic [SIZE_W-1:0]   size_value;
	logic [COLOR_W-1:0]  region_color_in;
	logic [PART_W-1:0]   partition;

	modport source (
		output valid, operation, entry_index, address, size_value, region_color_in,
		partition,
		input  ready
	);
	modport sink (
		input  valid, operation, entry_index, address, size_value, region_color_in,
		partition,
		output ready
	);
endinterface

interface cfa_rsp_if;
	import cfa_pkg::*;

	logic               valid;
	logic               ready;
	logic               status;
	logic [ADDR_W-1:0]  phys_address;
	logic [COLOR_W-1:0] granted_color;
	logic [SLOT_W-1:0]  frame_slot;

	modport source (
		output valid, status, phys_address, granted_color, frame_slot,
		input  ready
	);
	modport sink (
		input  valid, status, phys_address, granted_color, frame_slot,
		output ready
	);
endinterface

interface cfa_cfg_if;
	import cfa_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [REGCOUNT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> rtl/cfa_region_table.sv
// ----------------------------------------------------------------------------
// Colored first-fit allocator region table
// Base, size and color storage with one write port and one registered read.
// ----------------------------------------------------------------------------
module cfa_region_table #(
	parameter int unsigned MAX_REGIONS = 32,
	parameter int unsigned IDX_W       = 5
) (
	input  logic                        clk,
	input  cfa_pkg::tbl_wr_t            wr,
	input  logic                        rd_en,
	input  logic [IDX_W-1:0]            rd_addr,
	output logic [cfa_pkg::ADDR_W-1:0]  rd_base,
	output logic [cfa_pkg::SIZE_W-1:0]  rd_size,
	output logic [cfa_pkg::COLOR_W-1:0] rd_color
);
	import cfa_pkg::*;

	logic [ADDR_W-1:0]  base_mem  [MAX_REGIONS];
	logic [SIZE_W-1:0]  size_mem  [MAX_REGIONS];
	logic [COLOR_W-1:0] color_mem [MAX_REGIONS];
	logic [IDX_W-1:0]   wr_addr;

	assign wr_addr = IDX_W'(wr.idx);

	always_ff @(posedge clk) begin
		if (wr.en) begin
			base_mem[wr_addr]  <= wr.base;
			size_mem[wr_addr]  <= wr.size;
			color_mem[wr_addr] <= wr.color;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_base  <= base_mem[rd_addr];
			rd_size  <= size_mem[rd_addr];
			rd_color <= color_mem[rd_addr];
		end
	end

endmodule

>>> rtl/colored_first_fit_region_allocator.sv
// ----------------------------------------------------------------------------
// Colored first-fit region allocator
// Loads, allocates and releases colored memory regions with a first-fit scan.
// ----------------------------------------------------------------------------
// Channel  Direction  Transfer carries
// req      in         operation, entry_index, address, size_value,
//                     region_color_in, partition
// rsp      out        status, phys_address, granted_color, frame_slot
// cfg      in         region_count
//
// A load or unknown item goes from the idle state straight to the done state
// and then into the response register. Allocate and free walk the table one
// entry per cycle through the single read port, over n = min(region_count,
// MAX_REGIONS) entries; allocate stops early at its first fit. The request
// side is ready only while idle. A stalled response holds its register and
// the finished result waits in the sequencer. Reset clears the free flags,
// the count and the sequencer; the slot counter restarts at ten.
// ----------------------------------------------------------------------------
module colored_first_fit_region_allocator #(
	parameter int unsigned MAX_REGIONS = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	cfa_req_if.sink  req,
	cfa_rsp_if.source rsp,
	cfa_cfg_if.sink  cfg
);
	import cfa_pkg::*;

	localparam int unsigned IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_REGIONS + 1);

	state_t                state_q;
	logic [REGCOUNT_W-1:0] count_q;
	logic [SLOT_W-1:0]     slot_q;
	logic                  free_q [MAX_REGIONS];

	logic [OP_W-1:0]       op_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [SIZE_W-1:0]     size_q;
	logic [PART_SEL_W-1:0] want_q;
	logic [CNT_W-1:0]      n_q;
	logic [CNT_W-1:0]      iss_q;

	logic                  rd_vld_s1;
	logic                  last_s1;
	logic [IDX_W-1:0]      rd_idx_s1;

	logic                  res_status_q;
	logic [ADDR_W-1:0]     res_addr_q;
	logic [COLOR_W-1:0]    res_color_q;
	logic [SLOT_W-1:0]     res_slot_q;

	logic                  out_valid_q;
	logic                  out_status_q;
	logic [ADDR_W-1:0]     out_addr_q;
	logic [COLOR_W-1:0]    out_color_q;
	logic [SLOT_W-1:0]     out_slot_q;

	logic                  req_xfer;
	logic                  load_ok;
	logic [CNT_W-1:0]      n_d;
	tbl_wr_t               tbl_wr;
	logic                  rd_en;
	logic [ADDR_W-1:0]     rd_base;
	logic [SIZE_W-1:0]     rd_size;
	logic [COLOR_W-1:0]    rd_color;
	logic                  fit;
	logic                  grant;
	logic                  base_eq;
	logic                  finish;
	logic                  out_free;

	assign req_xfer  = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	assign load_ok = (32'(req.entry_index) < MAX_REGIONS);
	assign n_d = (32'(count_q) > MAX_REGIONS) ? CNT_W'(MAX_REGIONS) : CNT_W'(count_q);

	always_comb begin
		tbl_wr.en    = req_xfer && (req.operation == OP_LOAD) && load_ok;
		tbl_wr.idx   = req.entry_index;
		tbl_wr.base  = req.address;
		tbl_wr.size  = req.size_value;
		tbl_wr.color = req.region_color_in;
	end

	// The color matches when it equals twice the partition group or that plus one.
	assign fit = free_q[rd_idx_s1] && (rd_size >= size_q)
		&& (rd_color[COLOR_W-1:1] == (COLOR_W-1)'(want_q));
	assign grant   = (state_q == S_SCAN) && rd_vld_s1 && (op_q == OP_ALLOC) && fit;
	assign base_eq = rd_base == addr_q;
	assign finish  = grant || ((state_q == S_SCAN) && rd_vld_s1 && last_s1);
	assign rd_en   = (state_q == S_SCAN) && (iss_q != n_q) && !finish;
	assign out_free = !out_valid_q || rsp.ready;

	cfa_region_table #(
		.MAX_REGIONS (MAX_REGIONS),
		.IDX_W       (IDX_W)
	) u_table (
		.clk      (clk),
		.wr       (tbl_wr),
		.rd_en    (rd_en),
		.rd_addr  (iss_q[IDX_W-1:0]),
		.rd_base  (rd_base),
		.rd_size  (rd_size),
		.rd_color (rd_color)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			count_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_REGIONS; i++) begin
				free_q[i] <= 1'b0;
			end
		end else begin
			if (tbl_wr.en) begin
				free_q[IDX_W'(req.entry_index)] <= 1'b1;
			end
			if (grant) begin
				free_q[rd_idx_s1] <= 1'b0;
			end else if ((state_q == S_SCAN) && rd_vld_s1 && (op_q == OP_FREE) && base_eq) begin
				free_q[rd_idx_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			slot_q    <= SLOT_RESET;
			iss_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			unique case (state_q)
				S_IDLE: begin
					if (req_xfer) begin
						iss_q <= '0;
						if (((req.operation == OP_ALLOC) || (req.operation == OP_FREE))
								&& (n_d != '0)) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						iss_q <= iss_q + CNT_W'(1);
					end
					if (grant) begin
						slot_q <= slot_q + SLOT_W'(1);
					end
					if (finish) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_idx_s1 <= iss_q[IDX_W-1:0];
			last_s1   <= (iss_q == (n_q - CNT_W'(1)));
		end
		if (req_xfer) begin
			op_q         <= req.operation;
			addr_q       <= req.address;
			size_q       <= req.size_value;
			want_q       <= req.partition[PART_SEL_W-1:0];
			n_q          <= n_d;
			res_status_q <= (req.operation == OP_ALLOC) && (n_d == '0);
			res_addr_q   <= '0;
			res_color_q  <= '0;
			res_slot_q   <= '0;
		end else if (grant) begin
			res_status_q <= 1'b0;
			res_addr_q   <= rd_base;
			res_color_q  <= rd_color;
			res_slot_q   <= slot_q;
		end else if (finish && (op_q == OP_ALLOC)) begin
			res_status_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			out_status_q <= res_status_q;
			out_addr_q   <= res_addr_q;
			out_color_q  <= res_color_q;
			out_slot_q   <= res_slot_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.phys_address  = out_addr_q;
	assign rsp.granted_color = out_color_q;
	assign rsp.frame_slot    = out_slot_q;

	// The slot counter moves only on a grant during a scan.
	a_slot_only_on_grant: assert property (@(posedge clk) disable iff (!arst_n)
		!grant |=> $stable(slot_q))
		else $error("slot counter changed without a grant");

	// Table reads are in flight only while scanning.
	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == S_SCAN))
		else $error("table read pending outside a scan");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (iss_q <= n_q))
		else $error("scan index passed the entry count");

	// A failed allocation carries an all-zero payload.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status) |-> ((rsp.phys_address == '0)
			&& (rsp.granted_color == '0) && (rsp.frame_slot == '0)))
		else $error("failure response with nonzero payload");

endmodule

>>> tb/cfa_region_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region allocator checker
// Watches the request, configuration and response transfers of the allocator.
// Keeps its own region table, free map, slot counter and region count. Predicts
// one response per request and compares each response with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module cfa_region_checker #(
	parameter int unsigned MAX_REGIONS = 32
) (
	input  logic clk,
	input  logic arst_n,
	cfa_req_if   req,
	cfa_rsp_if   rsp,
	cfa_cfg_if   cfg,
	output int   mismatches,
	output int   outstanding
);
	import cfa_pkg::*;

	localparam logic ST_OK     = 1'b0;
	localparam logic ST_NO_FIT = 1'b1;

	typedef struct packed {
		logic               status;
		logic [ADDR_W-1:0]  phys;
		logic [COLOR_W-1:0] color;
		logic [SLOT_W-1:0]  slot;
	} grant_t;

	logic [ADDR_W-1:0]     base_tbl  [MAX_REGIONS];
	logic [SIZE_W-1:0]     size_tbl  [MAX_REGIONS];
	logic [COLOR_W-1:0]    color_tbl [MAX_REGIONS];
	logic [MAX_REGIONS-1:0] free_map;
	logic [SLOT_W-1:0]     next_slot;
	logic [REGCOUNT_W-1:0] region_count;
	grant_t                expected_grants [$];
	grant_t                oldest;

	task automatic predict_grant();
		grant_t             g;
		logic [COLOR_W-1:0] want;
		int unsigned        n;
		g = '0;
		g.status = ST_OK;
		n = (region_count > MAX_REGIONS) ? MAX_REGIONS : region_count;
		case (req.operation)
			OP_LOAD: begin
				if (req.entry_index < MAX_REGIONS) begin
					base_tbl[req.entry_index]  = req.address;
					size_tbl[req.entry_index]  = req.size_value;
					color_tbl[req.entry_index] = req.region_color_in;
					free_map[req.entry_index]  = 1'b1;
				end
			end
			OP_ALLOC: begin
				want = COLOR_W'({req.partition[PART_SEL_W-1:0], 1'b0});
				g.status = ST_NO_FIT;
				for (int i = 0; i < n; i++) begin
					if (free_map[i] && size_tbl[i] >= req.size_value &&
							(color_tbl[i] == want || color_tbl[i] == (want | COLOR_W'(1)))) begin
						free_map[i] = 1'b0;
						g.status = ST_OK;
						g.phys = base_tbl[i];
						g.color = color_tbl[i];
						g.slot = next_slot;
						next_slot = next_slot + 1'b1;
						break;
					end
				end
			end
			OP_FREE: begin
				for (int i = 0; i < n; i++) begin
					if (base_tbl[i] == req.address) begin
						free_map[i] = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		expected_grants.push_back(g);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_map = '0;
			next_slot = SLOT_RESET;
			region_count = '0;
			expected_grants.delete();
			outstanding = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				region_count = cfg.data;
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_grants.size() == 0) begin
					$error("response transfer with no request waiting");
					mismatches++;
				end else begin
					oldest = expected_grants.pop_front();
					if (rsp.status !== oldest.status) begin
						$error("status: expected %0d, got %0d", oldest.status, rsp.status);
						mismatches++;
					end
					if (rsp.phys_address !== oldest.phys) begin
						$error("phys_address: expected %h, got %h", oldest.phys, rsp.phys_address);
						mismatches++;
					end
					if (rsp.granted_color !== oldest.color) begin
						$error("granted_color: expected %h, got %h", oldest.color,
							rsp.granted_color);
						mismatches++;
					end
					if (rsp.frame_slot !== oldest.slot) begin
						$error("frame_slot: expected %0d, got %0d", oldest.slot, rsp.frame_slot);
						mismatches++;
					end
				end
			end
			if (req.valid && req.ready) begin
				predict_grant();
			end
			outstanding = expected_grants.size();
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region allocator testbench
// Drives load, allocate, free and unknown requests into the allocator under
// several region counts, with random gaps on the request side and random
// stalls on the response side. A checker beside the block predicts and
// compares every response; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import cfa_pkg::*;

	localparam int unsigned MAX_REGIONS = 32;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_ITEMS = 150;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   idle_cycles;
	int   rsp_hold;
	int   rsp_gap;
	bit   calm;
	logic [ADDR_W-1:0] base_pool [8];

	cfa_req_if req_ch ();
	cfa_rsp_if rsp_ch ();
	cfa_cfg_if cfg_ch ();

	colored_first_fit_region_allocator #(
		.MAX_REGIONS(MAX_REGIONS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	cfa_region_checker #(
		.MAX_REGIONS(MAX_REGIONS)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg         (cfg_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return SIZE_W'($urandom_range(0, 4095));
		if (r < 70) return '0;
		if (r < 80) return '1;
		return rand64();
	endfunction

	function automatic logic [ADDR_W-1:0] pick_base();
		if ($urandom_range(0, 99) < 80) return base_pool[$urandom_range(0, 7)];
		return rand64();
	endfunction

	function automatic logic [COLOR_W-1:0] pick_color();
		if ($urandom_range(0, 99) < 85) return COLOR_W'($urandom_range(0, 15));
		return COLOR_W'($urandom);
	endfunction

	always @(posedge clk) begin
		if (rsp_hold > 0) begin
			rsp_hold <= rsp_hold - 1;
		end else begin
			rsp_gap = pick_gap();
			rsp_ch.ready <= (rsp_gap == 0);
			rsp_hold <= (rsp_gap > 0) ? rsp_gap - 1 : 0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("colored_first_fit_region_allocator verification failed");
			$finish;
		end
	end

	task automatic send(input logic [OP_W-1:0] op, input logic [ENTRY_W-1:0] idx,
			input logic [ADDR_W-1:0] addr, input logic [SIZE_W-1:0] sz,
			input logic [COLOR_W-1:0] color, input logic [PART_W-1:0] part);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.entry_index <= idx;
		req_ch.address <= addr;
		req_ch.size_value <= sz;
		req_ch.region_color_in <= color;
		req_ch.partition <= part;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
	endtask

	task automatic send_random();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			send(OP_LOAD, ENTRY_W'($urandom_range(0, MAX_REGIONS - 1)), pick_base(),
				pick_size(), pick_color(), $urandom);
		end else if (r < 80) begin
			send(OP_ALLOC, ENTRY_W'($urandom), rand64(), pick_size(), COLOR_W'($urandom),
				$urandom);
		end else if (r < 97) begin
			send(OP_FREE, ENTRY_W'($urandom), pick_base(), rand64(), COLOR_W'($urandom),
				$urandom);
		end else begin
			send(OP_UNUSED, ENTRY_W'($urandom), rand64(), rand64(), COLOR_W'($urandom),
				$urandom);
		end
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_region_count(input logic [REGCOUNT_W-1:0] value);
		settle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		logic [REGCOUNT_W-1:0] phase_counts [6];
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.operation <= OP_LOAD;
		req_ch.entry_index <= '0;
		req_ch.address <= '0;
		req_ch.size_value <= '0;
		req_ch.region_color_in <= '0;
		req_ch.partition <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;
		calm = 1'b0;
		base_pool[0] = '0;
		base_pool[1] = '1;
		for (int i = 2; i < 8; i++) begin
			base_pool[i] = rand64() & ~64'hFFF;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With the reset count of zero nothing is scanned, so the allocation fails.
		send(OP_ALLOC, '0, '0, '0, '0, '0);
		send(OP_FREE, '1, '1, '1, '1, '1);
		send(OP_UNUSED, '1, '1, '1, '1, '1);

		for (int i = 0; i < MAX_REGIONS; i++) begin
			send(OP_LOAD, ENTRY_W'(i), pick_base(), pick_size(), pick_color(), $urandom);
		end
		send(OP_LOAD, '0, '1, '1, COLOR_W'(15), '0);
		send(OP_LOAD, ENTRY_W'(MAX_REGIONS - 1), '0, '0, '0, '1);
		send(OP_LOAD, ENTRY_W'(7), base_pool[2], SIZE_W'(4096), '1, '0);
		send(OP_LOAD, ENTRY_W'(8), base_pool[2], SIZE_W'(4096), COLOR_W'(6), '0);

		// A count above the table size scans the whole table.
		set_region_count('1);
		send(OP_ALLOC, '0, '0, '1, '0, '1);
		send(OP_ALLOC, '0, '0, '1, '0, '1);
		send(OP_FREE, '0, '1, '0, '0, '0);
		send(OP_ALLOC, '0, '0, SIZE_W'(4096), '0, 32'hFFFF_FFFB);
		send(OP_FREE, '0, base_pool[2], '0, '0, '0);
		send(OP_ALLOC, '0, '0, '0, '0, PART_W'(8));
		send(OP_ALLOC, '0, '0, '0, '0, '0);

		phase_counts = '{REGCOUNT_W'(1), REGCOUNT_W'(32), REGCOUNT_W'(0), '1,
			REGCOUNT_W'(17), REGCOUNT_W'(0)};
		phase_counts[5] = REGCOUNT_W'($urandom);
		for (int p = 0; p < 6; p++) begin
			calm = (p == 4);
			set_region_count(phase_counts[p]);
			repeat (PHASE_ITEMS) send_random();
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("colored_first_fit_region_allocator verification clean");
		end else begin
			$display("colored_first_fit_region_allocator verification failed");
		end
		$finish;
	end

endmodule
